FILE: sv/graph_stack_traversal_unit_assert.svh
// assertion macros shared by the graph stack traversal rtl
// expects clk and rst_n to be visible where a macro is used
`ifndef GRAPH_STACK_TRAVERSAL_UNIT_ASSERT_SVH
`define GRAPH_STACK_TRAVERSAL_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define GST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define GST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/gst_pkg.sv
// shared types and constants for the graph stack traversal unit
// no dependencies
package gst_pkg;

    // defaults and fixed field widths
    localparam int MAX_VERTICES_DEF = 8;
    localparam int ROW_WIDTH        = 8;
    localparam int VERTEX_W         = 3;
    localparam int COUNT_W          = 4;
    localparam logic [COUNT_W-1:0] VCOUNT_RESET = 4'd8;

    // input word action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_WALK = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_FETCH,
        ST_SCAN,
        ST_PUSH
    } gst_state_t;

    // adjacency memory request
    typedef struct packed {
        logic                 wr_en;
        logic [VERTEX_W-1:0]  wr_addr;
        logic [ROW_WIDTH-1:0] wr_data;
        logic [VERTEX_W-1:0]  rd_addr;
    } adj_req_t;

endpackage

FILE: sv/gst_adj_mem.sv
// adjacency row memory with per-row valid flags and a registered read
// depends on gst_pkg
module gst_adj_mem #(
    parameter int MAX_VERTICES = gst_pkg::MAX_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gst_pkg::adj_req_t             req,
    output logic [gst_pkg::ROW_WIDTH-1:0] row_data
);
    import gst_pkg::*;

    localparam int ROWS  = (MAX_VERTICES < ROW_WIDTH) ? MAX_VERTICES : ROW_WIDTH;
    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROW_WIDTH-1:0] mem [ROWS];
    logic [ROWS-1:0]      row_valid_reg;
    logic [ROW_WIDTH-1:0] rd_data_reg;
    logic                 rd_ok_reg;
    logic                 wr_hit;
    logic                 rd_hit;
    logic [IDX_W-1:0]     wr_idx;
    logic [IDX_W-1:0]     rd_idx;

    // rows outside the stored range are dropped on write and read as zero
    assign wr_hit = req.wr_en && ({1'b0, req.wr_addr} < (VERTEX_W+1)'(ROWS));
    assign rd_hit = ({1'b0, req.rd_addr} < (VERTEX_W+1)'(ROWS));
    assign wr_idx = req.wr_addr[IDX_W-1:0];
    assign rd_idx = req.rd_addr[IDX_W-1:0];

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_idx] <= req.wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    // valid flags make unwritten rows read as zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                row_valid_reg[wr_idx] <= 1'b1;
            end
            rd_ok_reg <= rd_hit && row_valid_reg[rd_idx];
        end
    end

    assign row_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

FILE: sv/gst_stack_mem.sv
// vertex stack storage, one write and one registered read per cycle
// depends on gst_pkg
module gst_stack_mem #(
    parameter int DEPTH  = gst_pkg::MAX_VERTICES_DEF,
    parameter int ADDR_W = $clog2(gst_pkg::MAX_VERTICES_DEF)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            waddr,
    input  logic [gst_pkg::VERTEX_W-1:0] wdata,
    input  logic [ADDR_W-1:0]            raddr,
    output logic [gst_pkg::VERTEX_W-1:0] rdata
);
    import gst_pkg::*;

    logic [VERTEX_W-1:0] mem [DEPTH];
    logic [VERTEX_W-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/gst_ctrl.sv
// traversal sequencer: row loads, pop, row fetch, neighbour scan, pushes and output word
// depends on gst_pkg and graph_stack_traversal_unit_assert.svh
module gst_ctrl #(
    parameter int MAX_VERTICES = gst_pkg::MAX_VERTICES_DEF,
    parameter int SA_W         = $clog2(gst_pkg::MAX_VERTICES_DEF)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [gst_pkg::VERTEX_W-1:0]  row_index,
    input  logic [gst_pkg::ROW_WIDTH-1:0] row_bits,
    input  logic [gst_pkg::VERTEX_W-1:0]  start_vertex,
    input  logic [gst_pkg::ROW_WIDTH-1:0] scan_mask,
    output gst_pkg::adj_req_t             adj_req,
    input  logic [gst_pkg::ROW_WIDTH-1:0] adj_row,
    output logic                          stk_we,
    output logic [SA_W-1:0]               stk_waddr,
    output logic [gst_pkg::VERTEX_W-1:0]  stk_wdata,
    output logic [SA_W-1:0]               stk_raddr,
    input  logic [gst_pkg::VERTEX_W-1:0]  stk_rdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gst_pkg::VERTEX_W-1:0]  vertex,
    output logic                          last
);
    import gst_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);

    gst_state_t           state_reg, state_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [ROW_WIDTH-1:0] visited_reg, visited_next;
    logic [ROW_WIDTH-1:0] pending_reg, pending_next;
    logic [VERTEX_W-1:0]  cur_v_reg, cur_v_next;
    logic                 out_valid_reg;
    logic [VERTEX_W-1:0]  out_vertex_reg;
    logic                 out_last_reg;

    logic [ROW_WIDTH-1:0] lowest;
    logic [VERTEX_W-1:0]  low_idx;
    logic [DEPTH_W-1:0]   depth_dec;
    logic                 stack_full;
    logic                 out_free;
    logic                 out_load;
    logic                 emit_last;

    // lowest pending neighbour, pushed first
    always_comb
    begin
        lowest  = pending_reg & (~pending_reg + ROW_WIDTH'(1));
        low_idx = '0;
        for (int i = 0; i < ROW_WIDTH; i++)
        begin
            if (lowest[i])
            begin
                low_idx = VERTEX_W'(i);
            end
        end
    end

    assign depth_dec  = depth_reg - DEPTH_W'(1);
    assign stack_full = (depth_reg == DEPTH_W'(MAX_VERTICES));
    assign out_free   = !out_valid_reg || out_ready;
    assign emit_last  = out_load && (depth_reg == '0);

    // state register and walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            visited_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            visited_reg <= visited_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_v_reg <= cur_v_next;
    end

    // next state, memory requests and output load
    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        visited_next    = visited_reg;
        pending_next    = pending_reg;
        cur_v_next      = cur_v_reg;
        in_ready        = 1'b0;
        out_load        = 1'b0;
        adj_req.wr_en   = 1'b0;
        adj_req.wr_addr = row_index;
        adj_req.wr_data = row_bits;
        adj_req.rd_addr = stk_rdata;
        stk_we          = 1'b0;
        stk_waddr       = depth_reg[SA_W-1:0];
        stk_wdata       = low_idx;
        stk_raddr       = depth_dec[SA_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action == ACT_LOAD)
                    begin
                        adj_req.wr_en = 1'b1;
                    end
                    else
                    begin
                        // fresh walk: mark and push the start vertex
                        visited_next = ROW_WIDTH'(1) << start_vertex;
                        stk_we       = 1'b1;
                        stk_waddr    = '0;
                        stk_wdata    = start_vertex;
                        depth_next   = DEPTH_W'(1);
                        state_next   = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                depth_next = depth_dec;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cur_v_next = stk_rdata;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                pending_next = adj_row & ~visited_reg & scan_mask;
                visited_next = visited_reg | (adj_row & scan_mask);
                state_next   = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (pending_reg != '0)
                begin
                    // a push onto a full stack is dropped
                    stk_we       = !stack_full;
                    depth_next   = stack_full ? depth_reg : depth_reg + DEPTH_W'(1);
                    pending_next = pending_reg & ~lowest;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = (depth_reg == '0) ? ST_IDLE : ST_POP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_vertex_reg <= cur_v_reg;
            out_last_reg   <= (depth_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign vertex    = out_vertex_reg;
    assign last      = out_last_reg;

    // checks
`include "graph_stack_traversal_unit_assert.svh"
    `GST_ASSERT_IMP(a_depth_bound, 1'b1, depth_reg <= DEPTH_W'(MAX_VERTICES), "stack depth overrun")
    `GST_ASSERT_IMP(a_idle_empty, state_reg == ST_IDLE, depth_reg == '0, "stack not empty when idle")
    `GST_ASSERT_IMP(a_pop_nonempty, state_reg == ST_POP, depth_reg != '0, "pop from empty stack")
    `GST_ASSERT_IMP(a_pend_visited, 1'b1, (pending_reg & ~visited_reg) == '0, "pending vertex unmarked")
    `GST_ASSERT_NXT(a_last_ends, emit_last, state_reg == ST_IDLE && out_last_reg, "walk did not end")

endmodule

FILE: sv/graph_stack_traversal_unit.sv
// Row load: written into the adjacency memory when taken in idle; no output word.
// Walk: each popped vertex passes through the pop (stack read), fetch (row read),
// scan and push states; its unvisited neighbours are pushed one at a time through
// the single write port of the stack memory before its output word is loaded, and
// the next input word is taken only after the walk ends, later under output stalls.
// Reset: stack empty, vertex count 8, all adjacency rows read as zero through
// per-row valid flags; no clearing pass.
module graph_stack_traversal_unit #(
    parameter int MAX_VERTICES = gst_pkg::MAX_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gst_pkg::COUNT_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [gst_pkg::VERTEX_W-1:0]  row_index,
    input  logic [gst_pkg::ROW_WIDTH-1:0] row_bits,
    input  logic [gst_pkg::VERTEX_W-1:0]  start_vertex,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gst_pkg::VERTEX_W-1:0]  vertex,
    output logic                          last
);
    import gst_pkg::*;

    localparam int SA_W = $clog2(MAX_VERTICES);

    logic [COUNT_W-1:0]   vertex_count_reg;
    logic [ROW_WIDTH-1:0] scan_mask;
    adj_req_t             adj_req;
    logic [ROW_WIDTH-1:0] adj_row;
    logic                 stk_we;
    logic [SA_W-1:0]      stk_waddr;
    logic [VERTEX_W-1:0]  stk_wdata;
    logic [SA_W-1:0]      stk_raddr;
    logic [VERTEX_W-1:0]  stk_rdata;

    // vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    // neighbours scanned only below the count, the stack depth and the row width
    always_comb
    begin
        for (int i = 0; i < ROW_WIDTH; i++)
        begin
            scan_mask[i] = (COUNT_W'(i) < vertex_count_reg) && (i < MAX_VERTICES);
        end
    end

    gst_adj_mem #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (adj_req),
        .row_data (adj_row)
    );

    gst_stack_mem #(
        .DEPTH  (MAX_VERTICES),
        .ADDR_W (SA_W)
    ) u_stack_mem (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    gst_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .SA_W         (SA_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .row_index    (row_index),
        .row_bits     (row_bits),
        .start_vertex (start_vertex),
        .scan_mask    (scan_mask),
        .adj_req      (adj_req),
        .adj_row      (adj_row),
        .stk_we       (stk_we),
        .stk_waddr    (stk_waddr),
        .stk_wdata    (stk_wdata),
        .stk_raddr    (stk_raddr),
        .stk_rdata    (stk_rdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex       (vertex),
        .last         (last)
    );

endmodule
